### sv/ceoe_pkg.sv
// Shared opcodes, state codes and memory size for the extended-opcode execute core.
`default_nettype none
package ceoe_pkg;

  localparam int MEM_ADDR_BITS = 16;
  localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;

  localparam logic [7:0] STACK_PAGE = 8'h01;
  localparam logic [7:0] SP_RESET   = 8'hFF;

  typedef enum logic [3:0] {
    OP_ADC_ZPI   = 4'd0,
    OP_ADC_ABSIY = 4'd1,
    OP_SBC_ZPI   = 4'd2,
    OP_SBC_ABSIY = 4'd3,
    OP_CMP       = 4'd4,
    OP_LDA       = 4'd5,
    OP_STA       = 4'd6,
    OP_JMP       = 4'd7,
    OP_JSR       = 4'd8,
    OP_PHX       = 4'd9,
    OP_PLX       = 4'd10,
    OP_PHY       = 4'd11,
    OP_PLY       = 4'd12,
    OP_EOM       = 4'd13,
    OP_LOAD      = 4'd14
  } opcode_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PUSH_HI,
    S_PUSH_LO,
    S_PTR_LO,
    S_PTR_HI,
    S_TGT,
    S_EXEC,
    S_PULL,
    S_PULL_DATA,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

### sv/cpu_extended_opcode_execute_core.sv
// Top level of the extended-opcode execute core: sequencer, registers and byte memory.
// Usage:
//   Input channel (in_valid / in_stall) carries one request: opcode, operand and
//   load_byte. Output channel (out_valid / out_stall) returns A, X, Y, S, PC and
//   the N/Z/C/V flags as they stand after that request.
// Steps, from the accepting edge to the result in the output register:
//   EOM, load, unused code: finish; PHX/PHY: push; PLX/PLY: pull, read;
//   STA, JMP: both pointer bytes, target; ADC/SBC/CMP/LDA: also execute;
//   JSR: push high, push low, then as JMP. The next request is taken once the
//   core is idle again. The single port of the byte memory sets this: every
//   pointer byte, operand and stack byte is one memory access, and each read depends on the last.
// Stall: a finished result waits in the output register while the next
//   request is accepted and worked on; that request then holds in its last
//   step until the output register is free.
// Reset: registers take their reset values (S = 0xFF, all else zero), then a
//   clearing pass writes zero to all 2^MEM_ADDR_BITS bytes, one per cycle;
//   in_stall stays high during the pass.
`default_nettype none
module cpu_extended_opcode_execute_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  opcode,
  input  wire logic [15:0] operand,
  input  wire logic [7:0]  load_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       acc_out,
  output logic [7:0]       x_out,
  output logic [7:0]       y_out,
  output logic [7:0]       sp_out,
  output logic [15:0]      pc_out,
  output logic             neg_flag,
  output logic             zero_flag,
  output logic             carry_flag,
  output logic             ovf_flag
);
  import ceoe_pkg::*;

  state_t state, state_next;

  logic [7:0]  acc, xr, yr, sp;
  logic [15:0] pc;
  logic        nf, zf, cf, vf;

  logic [3:0]  op_q;
  logic [15:0] ptr_addr;
  logic [7:0]  ptr_lo;
  logic [MEM_ADDR_BITS-1:0] clr_addr;

  logic                     ram_we;
  logic [15:0]              ram_addr16;
  logic [7:0]               ram_wdata;
  logic [7:0]               ram_rdata;

  logic        accept;
  logic        out_free;
  logic        is_zp;
  logic        is_absy;
  logic [15:0] ret_addr;
  logic [15:0] ptr_word;
  logic [15:0] tgt_addr;
  logic [7:0]  sp_inc;
  logic [7:0]  m_eff;
  logic        alu_cin;
  logic [8:0]  alu_sum;
  logic [7:0]  alu_res;
  logic        alu_ovf;

  ceoe_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr16[MEM_ADDR_BITS-1:0]),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign is_zp   = (op_q == OP_ADC_ZPI) || (op_q == OP_SBC_ZPI) || (op_q == OP_CMP) ||
                   (op_q == OP_LDA) || (op_q == OP_STA);
  assign is_absy = (op_q == OP_ADC_ABSIY) || (op_q == OP_SBC_ABSIY);

  assign ret_addr = pc + 16'd2;
  assign ptr_word = {ram_rdata, ptr_lo};
  assign tgt_addr = ptr_word + {8'h00, (is_absy ? yr : 8'h00)};
  assign sp_inc   = sp + 8'd1;

  // Subtract and compare run as add of the inverted operand.
  assign m_eff   = ((op_q == OP_SBC_ZPI) || (op_q == OP_SBC_ABSIY) || (op_q == OP_CMP))
                   ? ~ram_rdata : ram_rdata;
  assign alu_cin = (op_q == OP_CMP) ? 1'b1 : cf;
  assign alu_sum = {1'b0, acc} + {1'b0, m_eff} + {8'h00, alu_cin};
  assign alu_res = alu_sum[7:0];
  assign alu_ovf = (acc[7] ^ alu_res[7]) & (m_eff[7] ^ alu_res[7]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory port control.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_addr16 = ptr_addr;
    ram_wdata  = 8'h00;
    unique case (state)
      S_CLEAR: begin
        ram_we     = 1'b1;
        ram_addr16 = 16'(clr_addr);
        if (&clr_addr) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_addr16 = operand;
        ram_wdata  = load_byte;
        if (accept) begin
          unique case (opcode)
            OP_ADC_ZPI, OP_ADC_ABSIY, OP_SBC_ZPI, OP_SBC_ABSIY,
            OP_CMP, OP_LDA, OP_STA, OP_JMP: state_next = S_PTR_LO;
            OP_JSR:                          state_next = S_PUSH_HI;
            OP_PHX, OP_PHY:                  state_next = S_PUSH_LO;
            OP_PLX, OP_PLY:                  state_next = S_PULL;
            OP_LOAD: begin
              ram_we     = 1'b1;
              state_next = S_FIN;
            end
            default:                         state_next = S_FIN;
          endcase
        end
      end
      S_PUSH_HI: begin
        ram_we     = 1'b1;
        ram_addr16 = {STACK_PAGE, sp};
        ram_wdata  = ret_addr[15:8];
        state_next = S_PUSH_LO;
      end
      S_PUSH_LO: begin
        ram_we     = 1'b1;
        ram_addr16 = {STACK_PAGE, sp};
        unique case (op_q)
          OP_JSR:  ram_wdata = ret_addr[7:0];
          OP_PHX:  ram_wdata = xr;
          default: ram_wdata = yr;
        endcase
        state_next = (op_q == OP_JSR) ? S_PTR_LO : S_FIN;
      end
      S_PTR_LO: begin
        ram_addr16 = ptr_addr;
        state_next = S_PTR_HI;
      end
      S_PTR_HI: begin
        ram_addr16 = ptr_addr;
        state_next = S_TGT;
      end
      S_TGT: begin
        ram_addr16 = tgt_addr;
        ram_wdata  = acc;
        unique case (op_q)
          OP_JMP, OP_JSR: state_next = S_FIN;
          OP_STA: begin
            ram_we     = 1'b1;
            state_next = S_FIN;
          end
          default: state_next = S_EXEC;
        endcase
      end
      S_EXEC: begin
        state_next = S_FIN;
      end
      S_PULL: begin
        ram_addr16 = {STACK_PAGE, sp_inc};
        state_next = S_PULL_DATA;
      end
      S_PULL_DATA: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Clearing counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Architectural registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 8'h00;
      xr  <= 8'h00;
      yr  <= 8'h00;
      sp  <= SP_RESET;
      pc  <= 16'h0000;
      nf  <= 1'b0;
      zf  <= 1'b0;
      cf  <= 1'b0;
      vf  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (opcode == OP_EOM)) begin
            pc <= pc + 16'd1;
          end
        end
        S_PUSH_HI: begin
          sp <= sp - 8'd1;
        end
        S_PUSH_LO: begin
          sp <= sp - 8'd1;
          if (op_q != OP_JSR) begin
            pc <= pc + 16'd1;
          end
        end
        S_TGT: begin
          unique case (op_q)
            OP_JMP, OP_JSR: pc <= ptr_word;
            OP_STA:         pc <= pc + 16'd2;
            default: ;
          endcase
        end
        S_EXEC: begin
          pc <= pc + (is_absy ? 16'd3 : 16'd2);
          unique case (op_q)
            OP_LDA: begin
              acc <= ram_rdata;
              nf  <= ram_rdata[7];
              zf  <= (ram_rdata == 8'h00);
            end
            OP_CMP: begin
              cf <= alu_sum[8];
              nf <= alu_res[7];
              zf <= (alu_res == 8'h00);
            end
            default: begin
              acc <= alu_res;
              cf  <= alu_sum[8];
              vf  <= alu_ovf;
              nf  <= alu_res[7];
              zf  <= (alu_res == 8'h00);
            end
          endcase
        end
        S_PULL: begin
          sp <= sp_inc;
        end
        S_PULL_DATA: begin
          pc <= pc + 16'd1;
          nf <= ram_rdata[7];
          zf <= (ram_rdata == 8'h00);
          if (op_q == OP_PLX) begin
            xr <= ram_rdata;
          end else begin
            yr <= ram_rdata;
          end
        end
        default: ;
      endcase
    end
  end

  // Request payload and pointer sequencing.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= opcode;
      unique case (opcode)
        OP_ADC_ZPI, OP_SBC_ZPI, OP_CMP, OP_LDA, OP_STA:
          ptr_addr <= {8'h00, operand[7:0]};
        OP_JSR:
          ptr_addr <= operand + {8'h00, xr};
        default:
          ptr_addr <= operand;
      endcase
    end else if (state == S_PTR_LO) begin
      // Zero-page pointers wrap within the page.
      ptr_addr <= is_zp ? {8'h00, ptr_addr[7:0] + 8'd1} : ptr_addr + 16'd1;
    end
    if (state == S_PTR_HI) begin
      ptr_lo <= ram_rdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      acc_out    <= acc;
      x_out      <= xr;
      y_out      <= yr;
      sp_out     <= sp;
      pc_out     <= pc;
      neg_flag   <= nf;
      zero_flag  <= zf;
      carry_flag <= cf;
      ovf_flag   <= vf;
    end
  end

`ifndef SYNTHESIS
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_IDLE || state == S_PUSH_HI ||
                state == S_PUSH_LO || state == S_TGT))
    else $error("memory write outside a write step");

  a_push_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH_HI) |=> (sp == $past(sp) - 8'd1))
    else $error("stack pointer not decremented on push");

  a_exec_op: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> (op_q == OP_ADC_ZPI || op_q == OP_ADC_ABSIY ||
                           op_q == OP_SBC_ZPI || op_q == OP_SBC_ABSIY ||
                           op_q == OP_CMP || op_q == OP_LDA))
    else $error("execute step with a non-ALU opcode");
`endif

endmodule
`default_nettype wire

### sv/ceoe_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module ceoe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### verif/cpu_extended_opcode_execute_core_tb.sv
`timescale 1ns / 1ps
// Testbench for the extended-opcode execute core: random programs checked against a shadow CPU.
module cpu_extended_opcode_execute_core_tb;
  import ceoe_pkg::*;

  localparam logic [3:0] OP_UNUSED  = 4'd15;
  localparam int         PROG_LEN   = 1550;
  localparam int         QUIET_TAIL = 200;

  typedef struct packed {
    logic [3:0]  opc;
    logic [15:0] addr;
    logic [7:0]  lbyte;
  } instr_t;

  typedef struct packed {
    logic [7:0]  a, x, y, s;
    logic [15:0] pc;
    logic        n, z, c, v;
  } regs_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [3:0]  opcode    = '0;
  logic [15:0] operand   = '0;
  logic [7:0]  load_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  acc_out, x_out, y_out, sp_out;
  logic [15:0] pc_out;
  logic        neg_flag, zero_flag, carry_flag, ovf_flag;

  instr_t program_q[$];
  regs_t  regs_due[$];
  int     mismatches = 0;
  logic   req_taken  = 1'b0;
  int     gap_left   = 0;
  int     stall_left = 0;

  // shadow CPU
  logic [7:0]  sh_a  = '0;
  logic [7:0]  sh_x  = '0;
  logic [7:0]  sh_y  = '0;
  logic [7:0]  sh_s  = SP_RESET;
  logic [15:0] sh_pc = '0;
  logic        sh_n  = 1'b0;
  logic        sh_z  = 1'b0;
  logic        sh_c  = 1'b0;
  logic        sh_v  = 1'b0;
  logic [7:0]  sh_mem [MEM_DEPTH];

  cpu_extended_opcode_execute_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .operand    (operand),
    .load_byte  (load_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .acc_out    (acc_out),
    .x_out      (x_out),
    .y_out      (y_out),
    .sp_out     (sp_out),
    .pc_out     (pc_out),
    .neg_flag   (neg_flag),
    .zero_flag  (zero_flag),
    .carry_flag (carry_flag),
    .ovf_flag   (ovf_flag)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] mem_rd(logic [15:0] addr);
    return sh_mem[addr & 16'(MEM_DEPTH - 1)];
  endfunction

  function automatic void mem_wr(logic [15:0] addr, logic [7:0] b);
    sh_mem[addr & 16'(MEM_DEPTH - 1)] = b;
  endfunction

  // zero-page pointer: high byte wraps within page 0
  function automatic logic [15:0] zp_ptr(logic [15:0] addr);
    logic [7:0] nxt;
    nxt = addr[7:0] + 8'd1;
    return {mem_rd({8'h00, nxt}), mem_rd({8'h00, addr[7:0]})};
  endfunction

  function automatic logic [15:0] abs_ptr(logic [15:0] addr);
    logic [15:0] nxt;
    nxt = addr + 16'd1;
    return {mem_rd(nxt), mem_rd(addr)};
  endfunction

  function automatic void set_nz(logic [7:0] b);
    sh_n = b[7];
    sh_z = (b == 8'h00);
  endfunction

  function automatic void add_carry(logic [7:0] m);
    logic [8:0] r;
    r = {1'b0, sh_a} + {1'b0, m} + 9'(sh_c);
    sh_v = (sh_a[7] ^ r[7]) & (m[7] ^ r[7]);
    sh_c = r[8];
    sh_a = r[7:0];
    set_nz(sh_a);
  endfunction

  function automatic void sub_borrow(logic [7:0] m);
    logic [8:0] r;
    logic       borrow;
    borrow = !sh_c;
    r = {1'b0, sh_a} - {1'b0, m} - 9'(borrow);
    sh_c = ({1'b0, sh_a} >= {1'b0, m} + 9'(borrow));
    sh_v = (sh_a[7] ^ r[7]) & (~m[7] ^ r[7]);
    sh_a = r[7:0];
    set_nz(sh_a);
  endfunction

  function automatic void push(logic [7:0] b);
    mem_wr({STACK_PAGE, sh_s}, b);
    sh_s = sh_s - 8'd1;
  endfunction

  function automatic logic [7:0] pull();
    sh_s = sh_s + 8'd1;
    return mem_rd({STACK_PAGE, sh_s});
  endfunction

  // Execute one instruction on the shadow CPU and return the registers after it.
  function automatic regs_t run_instr(instr_t ins);
    logic [15:0] ret;
    logic [7:0]  m;
    case (ins.opc)
      OP_ADC_ZPI: begin
        add_carry(mem_rd(zp_ptr(ins.addr)));
        sh_pc = sh_pc + 16'd2;
      end
      OP_ADC_ABSIY: begin
        add_carry(mem_rd(abs_ptr(ins.addr) + 16'(sh_y)));
        sh_pc = sh_pc + 16'd3;
      end
      OP_SBC_ZPI: begin
        sub_borrow(mem_rd(zp_ptr(ins.addr)));
        sh_pc = sh_pc + 16'd2;
      end
      OP_SBC_ABSIY: begin
        sub_borrow(mem_rd(abs_ptr(ins.addr) + 16'(sh_y)));
        sh_pc = sh_pc + 16'd3;
      end
      OP_CMP: begin
        m = mem_rd(zp_ptr(ins.addr));
        sh_c = (sh_a >= m);
        set_nz(sh_a - m);
        sh_pc = sh_pc + 16'd2;
      end
      OP_LDA: begin
        sh_a = mem_rd(zp_ptr(ins.addr));
        set_nz(sh_a);
        sh_pc = sh_pc + 16'd2;
      end
      OP_STA: begin
        mem_wr(zp_ptr(ins.addr), sh_a);
        sh_pc = sh_pc + 16'd2;
      end
      OP_JMP: sh_pc = abs_ptr(ins.addr);
      OP_JSR: begin
        // push first: the pointer may overlap the bytes just pushed
        ret = sh_pc + 16'd2;
        push(ret[15:8]);
        push(ret[7:0]);
        sh_pc = abs_ptr(ins.addr + 16'(sh_x));
      end
      OP_PHX: begin
        push(sh_x);
        sh_pc = sh_pc + 16'd1;
      end
      OP_PLX: begin
        sh_x = pull();
        set_nz(sh_x);
        sh_pc = sh_pc + 16'd1;
      end
      OP_PHY: begin
        push(sh_y);
        sh_pc = sh_pc + 16'd1;
      end
      OP_PLY: begin
        sh_y = pull();
        set_nz(sh_y);
        sh_pc = sh_pc + 16'd1;
      end
      OP_EOM: sh_pc = sh_pc + 16'd1;
      OP_LOAD: mem_wr(ins.addr, ins.lbyte);
      default: ;
    endcase
    return '{sh_a, sh_x, sh_y, sh_s, sh_pc, sh_n, sh_z, sh_c, sh_v};
  endfunction

  function automatic void report_mismatch(string what, regs_t exp, regs_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: exp a=%h x=%h y=%h s=%h pc=%h nzcv=%b%b%b%b",
               $time, what, exp.a, exp.x, exp.y, exp.s, exp.pc, exp.n, exp.z, exp.c, exp.v);
      $display("%0t: %s: got a=%h x=%h y=%h s=%h pc=%h nzcv=%b%b%b%b",
               $time, what, got.a, got.x, got.y, got.s, got.pc, got.n, got.z, got.c, got.v);
    end
  endfunction

  function automatic void queue_instr(logic [3:0] opc, logic [15:0] addr, logic [7:0] b);
    instr_t ins;
    ins.opc   = opc;
    ins.addr  = addr;
    ins.lbyte = b;
    program_q.push_back(ins);
  endfunction

  // cluster addresses so loads, pointers and stack traffic interact
  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return {8'h00, 8'($urandom)};
      2: return {STACK_PAGE, 8'($urandom)};
      3: return {8'hFF, 8'($urandom)};
      default: return {12'h200, 4'($urandom)};
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_zp_op();
    case ($urandom_range(0, 4))
      0: return OP_ADC_ZPI;
      1: return OP_SBC_ZPI;
      2: return OP_CMP;
      3: return OP_LDA;
      default: return OP_STA;
    endcase
  endfunction

  function automatic logic [3:0] pick_stack_op();
    case ($urandom_range(0, 4))
      0: return OP_PHX;
      1: return OP_PLX;
      2: return OP_PHY;
      3: return OP_PLY;
      default: return OP_EOM;
    endcase
  endfunction

  // check results, then predict the request taken at this edge
  always @(posedge clk) begin
    regs_t  got;
    instr_t cur;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        got = '{acc_out, x_out, y_out, sp_out, pc_out, neg_flag, zero_flag, carry_flag,
                ovf_flag};
        if (regs_due.size() == 0)
          report_mismatch("result with no request pending", '0, got);
        else if (got !== regs_due[0])
          report_mismatch("mismatch", regs_due.pop_front(), got);
        else
          void'(regs_due.pop_front());
      end
      if (in_valid && !in_stall) begin
        cur.opc   = opcode;
        cur.addr  = operand;
        cur.lbyte = load_byte;
        regs_due.push_back(run_instr(cur));
      end
    end
  end

  always @(negedge clk) begin
    instr_t ins;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // hold the stalled request
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (program_q.size() == 0) begin
      in_valid <= 1'b0;
    end else if (program_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      gap_left <= $urandom_range(0, 10);
    end else begin
      ins = program_q.pop_front();
      in_valid  <= 1'b1;
      opcode    <= ins.opc;
      operand   <= ins.addr;
      load_byte <= ins.lbyte;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (program_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    logic [15:0] ptr, tgt;
    logic [7:0]  zp;
    int          n;
    for (int i = 0; i < MEM_DEPTH; i++)
      sh_mem[i] = 8'h00;

    // directed: stack wrap both ways, pointer wrap in page 0 and at 0xFFFF,
    // indexed target wrap, V/C boundary values, JSR pointer over its own pushed bytes
    queue_instr(OP_EOM, 16'h0000, 8'h00);
    queue_instr(OP_UNUSED, 16'hFFFF, 8'hFF);
    queue_instr(OP_LOAD, 16'h0100, 8'h80);
    queue_instr(OP_PLX, 16'h0000, 8'h00);
    queue_instr(OP_PHX, 16'h0000, 8'h00);
    queue_instr(OP_PLY, 16'h0000, 8'h00);
    queue_instr(OP_LOAD, 16'h0010, 8'hF0);
    queue_instr(OP_LOAD, 16'h0011, 8'hFF);
    queue_instr(OP_LOAD, 16'hFFFF, 8'hC0);
    queue_instr(OP_LOAD, 16'h0000, 8'hFF);
    queue_instr(OP_LOAD, 16'h0040, 8'h01);
    queue_instr(OP_LOAD, 16'hFFF0, 8'h7F);
    queue_instr(OP_LDA, 16'h5510, 8'h00);
    queue_instr(OP_ADC_ABSIY, 16'hFFFF, 8'h00);
    queue_instr(OP_SBC_ZPI, 16'h00FF, 8'h00);
    queue_instr(OP_SBC_ABSIY, 16'hFFFF, 8'h00);
    queue_instr(OP_CMP, 16'h0010, 8'h00);
    queue_instr(OP_STA, 16'h0010, 8'h00);
    queue_instr(OP_ADC_ZPI, 16'h0010, 8'h00);
    queue_instr(OP_JMP, 16'hFFFF, 8'h00);
    queue_instr(OP_JSR, 16'h017F, 8'h00);
    queue_instr(OP_LOAD, 16'h0020, 8'h34);
    queue_instr(OP_LOAD, 16'h0021, 8'h12);
    queue_instr(OP_JSR, 16'hFFA0, 8'h00);
    queue_instr(OP_PHY, 16'h0000, 8'h00);
    queue_instr(OP_PLX, 16'h0000, 8'h00);

    while (program_q.size() < PROG_LEN) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // set up a zero-page pointer and its target, then use it
          zp  = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
          tgt = pick_addr();
          queue_instr(OP_LOAD, {8'h00, zp}, tgt[7:0]);
          queue_instr(OP_LOAD, {8'h00, 8'(zp + 8'd1)}, tgt[15:8]);
          queue_instr(OP_LOAD, tgt, pick_byte());
          n = $urandom_range(1, 3);
          repeat (n) queue_instr(pick_zp_op(), {8'($urandom), zp}, 8'($urandom));
        end
        4, 5: begin
          ptr = pick_addr();
          tgt = pick_addr();
          queue_instr(OP_LOAD, ptr, tgt[7:0]);
          queue_instr(OP_LOAD, ptr + 16'd1, tgt[15:8]);
          for (int k = 0; k < 3; k++)
            queue_instr(OP_LOAD, tgt + 16'(k), pick_byte());
          queue_instr($urandom_range(0, 1) ? OP_ADC_ABSIY : OP_SBC_ABSIY, ptr,
                      8'($urandom));
        end
        6: begin
          ptr = pick_addr();
          queue_instr(OP_LOAD, ptr, 8'($urandom));
          queue_instr(OP_LOAD, ptr + 16'd1, 8'($urandom));
          queue_instr($urandom_range(0, 1) ? OP_JMP : OP_JSR, ptr, 8'($urandom));
        end
        7, 8: begin
          if ($urandom_range(0, 1))
            queue_instr(OP_LOAD, {STACK_PAGE, 8'($urandom)}, pick_byte());
          n = $urandom_range(1, 6);
          repeat (n) queue_instr(pick_stack_op(), 16'($urandom), 8'($urandom));
        end
        default: queue_instr(4'($urandom_range(0, 15)), 16'($urandom), 8'($urandom));
      endcase
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (program_q.size() != 0 || in_valid)
      @(posedge clk);
    while (regs_due.size() != 0)
      @(posedge clk);
    // catch any stray result after the last one
    repeat (20) @(posedge clk);

    if (mismatches == 0)
      $display("cpu_extended_opcode_execute_core_tb: clean");
    else
      $display("cpu_extended_opcode_execute_core_tb: errors");
    $finish;
  end

  // covers the memory clearing pass after reset with plenty of margin
  initial begin
    #10_000_000;
    $display("cpu_extended_opcode_execute_core_tb: errors");
    $finish;
  end

endmodule
